FILE: sv/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared beat types, command and error codes, controller states and the
// command/status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default configuration of the queue.
  localparam int DEPTH_DEFAULT      = 1024;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Fixed field widths of the request and response beats.
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int DATA_W  = 32;
  localparam int ERR_W   = 2;
  localparam int COUNT_W = 11;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Request beat.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] value;
  } req_t;

  // Response beat.
  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [ERR_W-1:0]   error;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;        // capture the request beat
    logic exec;         // apply the command to pointers and storage
    logic load_direct;  // load a response that needs no storage read
    logic load_read;    // load a response from the registered read data
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rsp_free;     // response register can take a beat this cycle
    logic needs_read;   // the held command reads a stored word
  } dp_status_t;

endpackage

FILE: sv/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request at a time: capture, execute, and an optional
// storage read cycle before the response is loaded.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  dq_pkg::dp_status_t     status,
  output dq_pkg::ctrl_cmd_t      ctrl
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next       = state;
    ctrl             = '0;
    req_stall        = 1'b1;
    unique case (state)
      dq_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          ctrl.latch = 1'b1;
          state_next = dq_pkg::ST_EXEC;
        end
      end
      dq_pkg::ST_EXEC: begin
        // Wait here until the response register can take the result.
        if (status.rsp_free) begin
          ctrl.exec = 1'b1;
          if (status.needs_read) begin
            state_next = dq_pkg::ST_READ;
          end else begin
            ctrl.load_direct = 1'b1;
            state_next       = dq_pkg::ST_IDLE;
          end
        end
      end
      dq_pkg::ST_READ: begin
        ctrl.load_read = 1'b1;
        state_next     = dq_pkg::ST_IDLE;
      end
      default: begin
        state_next = dq_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // A read cycle always follows an execute cycle.
  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == dq_pkg::ST_READ) |-> ($past(state) == dq_pkg::ST_EXEC))
    else $error("read cycle without a preceding execute cycle");

  // A captured request moves to the execute state in the next cycle.
  a_latch_to_exec: assert property (@(posedge clk) disable iff (rst)
    ctrl.latch |=> (state == dq_pkg::ST_EXEC))
    else $error("captured request did not move to execute");

  // Only one response load per command.
  a_single_load: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.load_direct && ctrl.load_read))
    else $error("two response loads in one cycle");
`endif

endmodule

FILE: sv/dq_datapath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular buffer storage, front pointer and entry count, wrap arithmetic
// for both ends, and the response register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dq_pkg::req_t           req,
  input  dq_pkg::ctrl_cmd_t      ctrl,
  output dq_pkg::dp_status_t     status,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output dq_pkg::rsp_t           rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  // Storage.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  // Held request.
  logic [dq_pkg::CMD_W-1:0] cmd_reg;
  logic [DATA_WIDTH-1:0]    value_reg;

  // Queue pointers.
  logic [IW-1:0] front;
  logic [IW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  // Derived positions and command decode.
  logic [SW-1:0]            sum_back;
  logic [SW-1:0]            sum_last;
  logic [IW-1:0]            back_slot;
  logic [IW-1:0]            last_slot;
  logic [IW-1:0]            front_dec;
  logic [IW-1:0]            front_inc;
  logic                     is_full;
  logic                     is_empty;
  logic                     wr_en;
  logic [IW-1:0]            wr_addr;
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic [dq_pkg::ERR_W-1:0] err;

  // Capture the request beat; the word is kept to the storage width.
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_reg   <= req.command;
      value_reg <= DATA_WIDTH'(req.value);
    end
  end

  // Wrapped positions at both ends of the buffer.
  always_comb begin
    is_full   = (count == CW'(DEPTH));
    is_empty  = (count == '0);
    sum_back  = SW'(front) + SW'(count);
    sum_last  = sum_back - SW'(1);
    back_slot = (sum_back >= SW'(DEPTH)) ? IW'(sum_back - SW'(DEPTH)) : IW'(sum_back);
    last_slot = (sum_last >= SW'(DEPTH)) ? IW'(sum_last - SW'(DEPTH)) : IW'(sum_last);
    front_dec = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
    front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + IW'(1);
  end

  // Command decode: pointer updates, storage access and error code.
  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = back_slot;
    rd_en      = 1'b0;
    rd_addr    = front;
    err        = dq_pkg::ERR_OK;
    unique case (cmd_reg)
      dq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          err = dq_pkg::ERR_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = front_dec;
          front_next = front_dec;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::CMD_PUSH_REAR: begin
        if (is_full) begin
          err = dq_pkg::ERR_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = back_slot;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          err = dq_pkg::ERR_EMPTY;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = front;
          front_next = front_inc;
          count_next = count - CW'(1);
        end
      end
      dq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          err = dq_pkg::ERR_EMPTY;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = last_slot;
          count_next = count - CW'(1);
        end
      end
      dq_pkg::CMD_PEEK_FRONT: begin
        if (is_empty) begin
          err = dq_pkg::ERR_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = front;
        end
      end
      dq_pkg::CMD_PEEK_BACK: begin
        if (is_empty) begin
          err = dq_pkg::ERR_EMPTY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = last_slot;
        end
      end
      default: begin
        // Unused codes leave the queue alone.
      end
    endcase
  end

  // Pointer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (ctrl.exec) begin
      front <= front_next;
      count <= count_next;
    end
  end

  // Storage write port.
  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[wr_addr] <= value_reg;
    end
  end

  // Storage read port with registered data.
  always_ff @(posedge clk) begin
    if (ctrl.exec && rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Response register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.load_direct || ctrl.load_read) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload. After a read the pointers already hold the new state.
  always_ff @(posedge clk) begin
    if (ctrl.load_direct) begin
      rsp.data     <= '0;
      rsp.error    <= err;
      rsp.count    <= dq_pkg::COUNT_W'(count_next);
      rsp.is_empty <= (count_next == '0);
    end else if (ctrl.load_read) begin
      rsp.data     <= dq_pkg::DATA_W'(rd_data);
      rsp.error    <= dq_pkg::ERR_OK;
      rsp.count    <= dq_pkg::COUNT_W'(count);
      rsp.is_empty <= is_empty;
    end
  end

  assign status.rsp_free   = !rsp_valid || !rsp_stall;
  assign status.needs_read = rd_en;

`ifndef SYNTH
  // The entry count never goes past the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  // The front pointer stays inside the buffer.
  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(front) < SW'(DEPTH))
    else $error("front pointer out of range");

  // A stalled response is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !(ctrl.load_direct || ctrl.load_read))
    else $error("response register overwritten while stalled");

  // A response that came from storage carries no error.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_read |=> (rsp_valid && rsp.error == dq_pkg::ERR_OK))
    else $error("read response loaded with an error code");
`endif

endmodule

FILE: sv/double_ended_queue.sv
// Timing: a push, a refused command or an unused code passes the capture
// register and the execute state into the response register; a pop or peek
// also passes the registered read of the storage memory in the read state.
// A new request is taken only in idle, after the last one is loaded, by the
// controller's capture, execute and read sequence; a stalled response
// holds the next command in execute. Reset clears state, pointers and count.
// ----------------------------------------------------------------------------
// Double-ended queue
// Circular buffer of DEPTH words with push, pop and peek at either end;
// every request beat gives one response beat.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dq_pkg::req_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dq_pkg::rsp_t  rsp
);

  dq_pkg::ctrl_cmd_t  ctrl;
  dq_pkg::dp_status_t status;

  // Sequencing of each request.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .ctrl      (ctrl)
  );

  // Storage, pointers and response register.
  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives command beats through a queue-fed driver and predicts every response
// beat from a shadow deque. Response beats are compared field by field with
// the predictions, in order. Directed, fill-and-drain and random traffic run
// under several sender idle and receiver stall mixes, plus a long hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH       = dq_pkg::DEPTH_DEFAULT;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 3000;
  localparam int FILL_LEVEL  = 100;

  // Command codes the block leaves unused.
  localparam logic [dq_pkg::CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [dq_pkg::CMD_W-1:0] CMD_UNUSED_B = 3'd7;

  logic clk = 1'b1;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  dq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  dq_pkg::rsp_t rsp;

  // Stimulus and checking state.
  dq_pkg::req_t cmd_queue[$];
  dq_pkg::rsp_t due_results[$];
  logic req_fire = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic pressure_on = 1'b0;
  int   hold_cnt = 0;
  int   stuck_cycles = 0;
  int   mismatches = 0;
  int   gen_count = 0;

  // Shadow deque used for prediction.
  logic [dq_pkg::DATA_W-1:0]  shadow_words [DEPTH];
  logic [IDX_W-1:0]           shadow_front = '0;
  logic [dq_pkg::COUNT_W-1:0] shadow_count = '0;

  double_ended_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Clock with a period of four time units.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one command to the shadow deque and return the response it gives.
  function automatic dq_pkg::rsp_t deque_apply(dq_pkg::req_t r);
    dq_pkg::rsp_t o;
    logic [IDX_W-1:0] slot;
    o = '0;
    o.error = dq_pkg::ERR_OK;
    case (r.command)
      dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
        if (shadow_count == dq_pkg::COUNT_W'(DEPTH)) begin
          o.error = dq_pkg::ERR_FULL;
        end else begin
          if (r.command == dq_pkg::CMD_PUSH_FRONT) begin
            shadow_front = shadow_front - IDX_W'(1);
            slot = shadow_front;
          end else begin
            slot = shadow_front + shadow_count[IDX_W-1:0];
          end
          shadow_words[slot] = r.value;
          shadow_count = shadow_count + dq_pkg::COUNT_W'(1);
        end
      end
      dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_BACK,
      dq_pkg::CMD_PEEK_FRONT, dq_pkg::CMD_PEEK_BACK: begin
        if (shadow_count == '0) begin
          o.error = dq_pkg::ERR_EMPTY;
        end else begin
          if (r.command == dq_pkg::CMD_POP_FRONT || r.command == dq_pkg::CMD_PEEK_FRONT) begin
            slot = shadow_front;
          end else begin
            slot = shadow_front + shadow_count[IDX_W-1:0] - IDX_W'(1);
          end
          o.data = shadow_words[slot];
          if (r.command == dq_pkg::CMD_POP_FRONT) begin
            shadow_front = shadow_front + IDX_W'(1);
            shadow_count = shadow_count - dq_pkg::COUNT_W'(1);
          end else if (r.command == dq_pkg::CMD_POP_BACK) begin
            shadow_count = shadow_count - dq_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    o.count = shadow_count;
    o.is_empty = (shadow_count == '0);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Queue one command beat, tracking the fill level for the generator.
  task automatic add_cmd(input logic [dq_pkg::CMD_W-1:0] c,
                         input logic [dq_pkg::VALUE_W-1:0] v);
    dq_pkg::req_t r;
    r.command = c;
    r.value = v;
    cmd_queue.insert(cmd_queue.size(), r);
    if ((c == dq_pkg::CMD_PUSH_FRONT || c == dq_pkg::CMD_PUSH_REAR) && gen_count < DEPTH) begin
      gen_count++;
    end else if ((c == dq_pkg::CMD_POP_FRONT || c == dq_pkg::CMD_POP_BACK) &&
                 gen_count > 0) begin
      gen_count--;
    end
  endtask

  task automatic add_read();
    int r;
    r = $urandom_range(9);
    if (r < 4) begin
      add_cmd(dq_pkg::CMD_POP_FRONT, $urandom);
    end else if (r < 7) begin
      add_cmd(dq_pkg::CMD_POP_BACK, $urandom);
    end else if (r < 8) begin
      add_cmd(dq_pkg::CMD_PEEK_FRONT, $urandom);
    end else begin
      add_cmd(dq_pkg::CMD_PEEK_BACK, $urandom);
    end
  endtask

  task automatic add_push();
    add_cmd($urandom_range(1) ? dq_pkg::CMD_PUSH_REAR : dq_pkg::CMD_PUSH_FRONT, $urandom);
  endtask

  // Random bursts leaning toward pushes, toward pops, or evenly mixed.
  task automatic random_traffic(input int n);
    int made;
    int len;
    int push_pct;
    int r;
    made = 0;
    while (made < n) begin
      len = $urandom_range(40, 4);
      case ($urandom_range(2))
        0: push_pct = 75;
        1: push_pct = 20;
        default: push_pct = 45;
      endcase
      if (gen_count == 0) begin
        push_pct = 80;
      end
      repeat (len) begin
        r = $urandom_range(99);
        if (r < 2) begin
          add_cmd($urandom_range(1) ? CMD_UNUSED_A : CMD_UNUSED_B, $urandom);
        end else if (r < 2 + push_pct) begin
          add_push();
        end else begin
          add_read();
        end
        made++;
      end
    end
  endtask

  // Fill the deque to the given level, then drain it dry and knock on it empty.
  task automatic fill_and_empty(input int level);
    while (gen_count < level) begin
      if ($urandom_range(9) == 0) begin
        add_cmd($urandom_range(1) ? dq_pkg::CMD_PEEK_BACK : dq_pkg::CMD_PEEK_FRONT, $urandom);
      end else begin
        add_push();
      end
    end
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, $urandom);
    add_cmd(dq_pkg::CMD_PEEK_BACK, $urandom);
    while (gen_count > 0) begin
      if ($urandom_range(9) == 0) begin
        add_cmd($urandom_range(1) ? dq_pkg::CMD_PEEK_BACK : dq_pkg::CMD_PEEK_FRONT, $urandom);
      end else begin
        add_cmd($urandom_range(1) ? dq_pkg::CMD_POP_BACK : dq_pkg::CMD_POP_FRONT, $urandom);
      end
    end
    add_cmd(dq_pkg::CMD_POP_FRONT, $urandom);
    add_cmd(dq_pkg::CMD_POP_BACK, $urandom);
  endtask

  // Wait until every queued beat is sent and every response is back.
  task automatic drain();
    while (cmd_queue.size() != 0 || req_valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Driver: offers the next command beat at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_fire) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req <= cmd_queue.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a single long hold-off when pressure is requested.
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      rsp_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predicts on each accepted command beat and checks each response.
  always @(posedge clk) begin : monitor
    dq_pkg::rsp_t want;
    dq_pkg::rsp_t pred;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        pred = deque_apply(req);
        due_results.insert(due_results.size(), pred);
      end
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("data", want.data, rsp.data);
          check_field("error", 32'(want.error), 32'(rsp.error));
          check_field("count", 32'(want.count), 32'(rsp.count));
          check_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        end
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty errors, unused codes, extreme words, both ends.
    add_cmd(dq_pkg::CMD_POP_FRONT, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'hFFFF_FFFF);
    add_cmd(CMD_UNUSED_A, 32'hFFFF_FFFF);
    add_cmd(CMD_UNUSED_B, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
    add_cmd(dq_pkg::CMD_PUSH_REAR, 32'h8000_0000);
    add_cmd(CMD_UNUSED_A, 32'h1234_5678);
    add_cmd(dq_pkg::CMD_PEEK_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PEEK_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_POP_BACK, 32'h0000_0000);
    add_cmd(dq_pkg::CMD_PUSH_REAR, 32'hA5A5_5A5A);
    add_cmd(dq_pkg::CMD_POP_FRONT, 32'h0000_0000);
    add_cmd(CMD_UNUSED_B, 32'hFFFF_FFFF);
    drain();

    // Fill and drain with the receiver held off at the start.
    pressure_on = 1'b1;
    fill_and_empty(FILL_LEVEL);
    drain();
    pressure_on = 1'b0;

    // Random traffic under each idling mix.
    random_traffic(150);
    drain();
    send_idle_pct = 80;
    random_traffic(150);
    drain();
    send_idle_pct = 0;
    stall_pct = 80;
    random_traffic(150);
    drain();
    send_idle_pct = 15;
    stall_pct = 15;
    random_traffic(150);
    drain();

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
